// ----- sv/bbps_pkg.sv -----
// Package: shared word types, event codes and the beep pattern table.
`timescale 1ns / 1ps

package bbps_pkg;

  // Action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_PLAY = 1'b1;

  // Event codes with special handling
  localparam logic [2:0] EV_OFF    = 3'd0;
  localparam logic [2:0] EV_BUTTON = 3'd1;
  localparam logic [2:0] EV_READY  = 3'd2;
  localparam logic [2:0] EV_START  = 3'd3;
  localparam logic [2:0] EV_STOP   = 3'd4;
  localparam logic [2:0] EV_DONE   = 3'd5;
  localparam logic [2:0] EV_ERROR  = 3'd6;
  localparam logic [2:0] EV_UNUSED = 3'd7;

  localparam int TIME_W  = 32;
  localparam int PULSE_W = 3;
  localparam int ON_W    = 10;
  localparam int OFF_W   = 9;

  typedef struct packed {
    logic              action;
    logic [2:0]        event_req;
    logic              error_lock;
    logic [TIME_W-1:0] now;
  } in_word_t;

  typedef struct packed {
    logic buzzer_on;
    logic busy_res;
  } out_word_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulses;
    logic [ON_W-1:0]    on_ms;
    logic [OFF_W-1:0]   off_ms;
  } pattern_t;

  // Fixed pattern per event; off and unused events map to an empty pattern
  function automatic pattern_t pattern_lookup(input logic [2:0] ev);
    pattern_t p;
    unique case (ev)
      EV_BUTTON: p = '{pulses: 3'd1, on_ms: 10'd300,  off_ms: 9'd150};
      EV_READY:  p = '{pulses: 3'd2, on_ms: 10'd300,  off_ms: 9'd150};
      EV_START:  p = '{pulses: 3'd3, on_ms: 10'd500,  off_ms: 9'd500};
      EV_STOP:   p = '{pulses: 3'd2, on_ms: 10'd1000, off_ms: 9'd150};
      EV_DONE:   p = '{pulses: 3'd4, on_ms: 10'd1000, off_ms: 9'd500};
      EV_ERROR:  p = '{pulses: 3'd4, on_ms: 10'd500,  off_ms: 9'd150};
      default:   p = '{pulses: 3'd0, on_ms: 10'd0,    off_ms: 9'd0};
    endcase
    return p;
  endfunction

endpackage

// ----- sv/buzzer_beep_pattern_sequencer_unit.sv -----
// Top level: buzzer beep pattern sequencer with input and result registers.
//
// Usage:
//   The input channel (in_valid/in_ready/in_data) takes one word per cycle unless stalled.
//   A word is either a millisecond tick (action 0) or a play request
//   (action 1) for an event; the event picks a fixed beep pattern.
//   Every input word yields exactly one result word on the output channel
//   (out_valid/out_ready/out_data): the buzzer drive level and the busy
//   flag after that word.
//   An accepted word passes the input register and then the result register.
//   Throughput: one word per cycle unless the receiver stalls; the state
//   update is a single 32-bit subtract and compare between the input and
//   result registers.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   sequence: buzzer off, not busy.
//   When the receiver stalls, the result stays in place, one more word
//   waits in the input register, and then in_ready drops until the
//   result is taken.
`timescale 1ns / 1ps

module buzzer_beep_pattern_sequencer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bbps_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bbps_pkg::out_word_t out_data
);

  logic                hold_valid;
  bbps_pkg::in_word_t  hold_data;
  logic                advance;
  logic                fire;
  bbps_pkg::out_word_t result;

  logic                out_valid_r, out_valid_nxt;
  bbps_pkg::out_word_t out_data_r;

  // Result slot free when empty or being taken
  assign advance = !out_valid_r || out_ready;
  assign fire    = hold_valid && advance;

  bbps_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (fire),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  bbps_seq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .word   (hold_data),
    .result (result)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/bbps_in_reg.sv -----
// Input register stage: holds one accepted word until the sequencer takes it.
`timescale 1ns / 1ps

module bbps_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bbps_pkg::in_word_t in_data,
  input  logic               take,
  output logic               hold_valid,
  output bbps_pkg::in_word_t hold_data
);

  logic               valid_r;
  logic               valid_nxt;
  bbps_pkg::in_word_t data_r;

  // Free when empty or when the held word leaves this cycle
  assign in_ready   = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

// ----- sv/bbps_seq_core.sv -----
// Sequencer core: beep state registers and the per-word next-state logic.
`timescale 1ns / 1ps

module bbps_seq_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  bbps_pkg::in_word_t  word,
  output bbps_pkg::out_word_t result
);

  logic [bbps_pkg::PULSE_W-1:0] pulses_left_r, pulses_left_nxt;
  logic                         seq_active_r, seq_active_nxt;
  logic                         level_high_r, level_high_nxt;
  logic [bbps_pkg::ON_W-1:0]    on_time_r, on_time_nxt;
  logic [bbps_pkg::OFF_W-1:0]   off_time_r, off_time_nxt;
  logic [bbps_pkg::TIME_W-1:0]  last_toggle_r, last_toggle_nxt;

  bbps_pkg::pattern_t          pat;
  logic [bbps_pkg::TIME_W-1:0] elapsed;
  logic                        on_done;
  logic                        off_done;

  assign pat      = bbps_pkg::pattern_lookup(word.event_req);
  // Wrapping elapsed time since last toggle
  assign elapsed  = word.now - last_toggle_r;
  assign on_done  = elapsed >= {{(bbps_pkg::TIME_W-bbps_pkg::ON_W){1'b0}}, on_time_r};
  assign off_done = elapsed >= {{(bbps_pkg::TIME_W-bbps_pkg::OFF_W){1'b0}}, off_time_r};

  // Next state for the word at hand
  always_comb begin
    pulses_left_nxt = pulses_left_r;
    seq_active_nxt  = seq_active_r;
    level_high_nxt  = level_high_r;
    on_time_nxt     = on_time_r;
    off_time_nxt    = off_time_r;
    last_toggle_nxt = last_toggle_r;
    if (word.action == bbps_pkg::ACT_PLAY) begin
      if (word.event_req == bbps_pkg::EV_OFF) begin
        pulses_left_nxt = '0;
        seq_active_nxt  = 1'b0;
        level_high_nxt  = 1'b0;
        on_time_nxt     = '0;
        off_time_nxt    = '0;
        last_toggle_nxt = '0;
      end else if (word.event_req != bbps_pkg::EV_UNUSED &&
                   (!word.error_lock || word.event_req == bbps_pkg::EV_ERROR)) begin
        // Start or restart with the new pattern
        pulses_left_nxt = pat.pulses;
        on_time_nxt     = pat.on_ms;
        off_time_nxt    = pat.off_ms;
        seq_active_nxt  = 1'b1;
        level_high_nxt  = 1'b1;
        last_toggle_nxt = word.now;
      end
    end else begin
      priority if (!seq_active_r) begin
        level_high_nxt = 1'b0;
      end else if (level_high_r) begin
        // On phase over: go quiet, use up a pulse
        if (on_done) begin
          level_high_nxt  = 1'b0;
          last_toggle_nxt = word.now;
          if (pulses_left_r != '0) begin
            pulses_left_nxt = pulses_left_r - 1'b1;
          end
        end
      end else if (off_done) begin
        if (pulses_left_r == '0) begin
          seq_active_nxt = 1'b0;
        end else begin
          level_high_nxt  = 1'b1;
          last_toggle_nxt = word.now;
        end
      end
    end
  end

  assign result.buzzer_on = level_high_nxt;
  assign result.busy_res  = seq_active_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulses_left_r <= '0;
      seq_active_r  <= 1'b0;
      level_high_r  <= 1'b0;
      on_time_r     <= '0;
      off_time_r    <= '0;
      last_toggle_r <= '0;
    end else if (fire) begin
      pulses_left_r <= pulses_left_nxt;
      seq_active_r  <= seq_active_nxt;
      level_high_r  <= level_high_nxt;
      on_time_r     <= on_time_nxt;
      off_time_r    <= off_time_nxt;
      last_toggle_r <= last_toggle_nxt;
    end
  end

endmodule

// ----- sv/bbps_checker.sv -----
// Port checker for the beep sequencer, bound to the top level.
`timescale 1ns / 1ps

module bbps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bbps_pkg::out_word_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

  // Buzzer only sounds during an active sequence
  a_on_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.buzzer_on |-> out_data.busy_res)
    else $error("buzzer on while not busy");

  // Empty result slot means input side is open
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Accepted word with a free output yields a result word
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing after accepted word");

endmodule

bind buzzer_beep_pattern_sequencer_unit bbps_checker u_bbps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/buzzer_beep_pattern_sequencer_unit_tb.sv -----
// Testbench: drives tick and play words into the beep sequencer and checks each result word.
`timescale 1ns / 1ps

module buzzer_beep_pattern_sequencer_unit_tb;
  import bbps_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int WORD_GOAL  = 2025;

  typedef struct {
    in_word_t    w;
    int unsigned gap;
    bit          drain;
  } send_slot_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  buzzer_beep_pattern_sequencer_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Words waiting to be sent and levels still owed by the block
  send_slot_t  words_to_send[$];
  out_word_t   levels_due[$];
  send_slot_t  slot;
  int unsigned gap_left   = 0;
  bit          gap_armed  = 1'b0;
  int unsigned stall_left = 0;
  int unsigned n_results  = 0;
  int unsigned n_err      = 0;
  int unsigned idle_cycles = 0;
  logic        in_taken;
  logic        out_taken;

  // Shadow of the sequencer state
  logic [PULSE_W-1:0] sh_pulses;
  logic               sh_active;
  logic               sh_level;
  logic [ON_W-1:0]    sh_on_ms;
  logic [OFF_W-1:0]   sh_off_ms;
  logic [TIME_W-1:0]  sh_last_ts;

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    sh_pulses = '0; sh_active = 1'b0; sh_level = 1'b0;
    sh_on_ms = '0; sh_off_ms = '0; sh_last_ts = '0;
  end

  always #5 clk = ~clk;

  // Advance the shadow state by one word and return the expected levels
  function automatic out_word_t beep_advance(input in_word_t w);
    logic [TIME_W-1:0] elapsed;
    out_word_t         r;
    if (w.action == ACT_PLAY) begin
      if (w.event_req == EV_OFF) begin
        sh_pulses = '0; sh_active = 1'b0; sh_level = 1'b0;
        sh_on_ms = '0; sh_off_ms = '0; sh_last_ts = '0;
      end else if (w.event_req != EV_UNUSED && (!w.error_lock || w.event_req == EV_ERROR)) begin
        case (w.event_req)
          EV_BUTTON: begin sh_pulses = 3'd1; sh_on_ms = 10'd300;  sh_off_ms = 9'd150; end
          EV_READY:  begin sh_pulses = 3'd2; sh_on_ms = 10'd300;  sh_off_ms = 9'd150; end
          EV_START:  begin sh_pulses = 3'd3; sh_on_ms = 10'd500;  sh_off_ms = 9'd500; end
          EV_STOP:   begin sh_pulses = 3'd2; sh_on_ms = 10'd1000; sh_off_ms = 9'd150; end
          EV_DONE:   begin sh_pulses = 3'd4; sh_on_ms = 10'd1000; sh_off_ms = 9'd500; end
          default:   begin sh_pulses = 3'd4; sh_on_ms = 10'd500;  sh_off_ms = 9'd150; end
        endcase
        sh_active  = 1'b1;
        sh_level   = 1'b1;
        sh_last_ts = w.now;
      end
    end else begin
      // wrapping elapsed time since the last toggle
      elapsed = w.now - sh_last_ts;
      if (!sh_active) begin
        sh_level = 1'b0;
      end else if (sh_level) begin
        if (elapsed >= TIME_W'(sh_on_ms)) begin
          sh_level   = 1'b0;
          sh_last_ts = w.now;
          if (sh_pulses != 0) sh_pulses = sh_pulses - 3'd1;
        end
      end else if (elapsed >= TIME_W'(sh_off_ms)) begin
        if (sh_pulses == 0) begin
          sh_active = 1'b0;
        end else begin
          sh_level   = 1'b1;
          sh_last_ts = w.now;
        end
      end
    end
    r.buzzer_on = sh_level;
    r.busy_res  = sh_active;
    return r;
  endfunction

  // Queue one word; the gap phase and the drain points follow the word count
  task automatic push_word(input logic act, input logic [2:0] ev, input logic lk,
                           input logic [TIME_W-1:0] ts);
    send_slot_t s;
    s.w.action     = act;
    s.w.event_req  = ev;
    s.w.error_lock = lk;
    s.w.now        = ts;
    s.gap   = (((words_to_send.size() / 250) % 3) == 1) ? 0 : $urandom_range(0, 9);
    s.drain = ((words_to_send.size() % 500) == 24);
    words_to_send.push_back(s);
  endtask

  // Driver: one word at a time, idle gap before each
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (words_to_send.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        if (!gap_armed) begin
          gap_left  = words_to_send[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (words_to_send[0].drain && levels_due.size() != 0) begin
          // hold off until the block has delivered everything
          in_valid <= 1'b0;
        end else begin
          slot = words_to_send.pop_front();
          in_data   <= slot.w;
          in_valid  <= 1'b1;
          gap_armed = 1'b0;
        end
      end
    end
  end

  // Receiver: random stall before each result, calm stretches in between
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken)
        stall_left = (((n_results / 300) % 3) == 1) ? 0 : $urandom_range(0, 9);
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: check results against the oldest expectation, predict accepted words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results = n_results + 1;
        if (levels_due.size() == 0) begin
          $display("%0t: unexpected result word: buzzer_on %0b busy_res %0b",
                   $time, out_data.buzzer_on, out_data.busy_res);
          n_err = n_err + 1;
        end else begin
          if (out_data.buzzer_on !== levels_due[0].buzzer_on) begin
            $display("%0t: buzzer_on mismatch: expected %0b, actual %0b",
                     $time, levels_due[0].buzzer_on, out_data.buzzer_on);
            n_err = n_err + 1;
          end
          if (out_data.busy_res !== levels_due[0].busy_res) begin
            $display("%0t: busy_res mismatch: expected %0b, actual %0b",
                     $time, levels_due[0].busy_res, out_data.busy_res);
            n_err = n_err + 1;
          end
          void'(levels_due.pop_front());
        end
      end
      if (in_valid && in_ready)
        levels_due.push_back(beep_advance(in_data));
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("buzzer_beep_pattern_sequencer_unit_tb: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [TIME_W-1:0] clock_ms;
    int unsigned       pick;
    int unsigned       n_ticks;
    int unsigned       step_ms;

    // idle ticks at both ends of the time range
    push_word(ACT_TICK, EV_UNUSED, 1'b1, 32'h0000_0000);
    push_word(ACT_TICK, EV_OFF,    1'b0, 32'hFFFF_FFFF);
    // unused event, and a locked request that must be ignored
    push_word(ACT_PLAY, EV_UNUSED, 1'b0, 32'd10);
    push_word(ACT_PLAY, EV_BUTTON, 1'b1, 32'd20);
    // single beep, one short of and exactly on each boundary
    push_word(ACT_PLAY, EV_BUTTON, 1'b0, 32'd100);
    push_word(ACT_TICK, EV_OFF,    1'b0, 32'd399);
    push_word(ACT_TICK, EV_OFF,    1'b0, 32'd400);
    push_word(ACT_TICK, EV_OFF,    1'b0, 32'd549);
    push_word(ACT_TICK, EV_OFF,    1'b0, 32'd550);
    push_word(ACT_TICK, EV_OFF,    1'b0, 32'd600);
    // error event plays under the lock, across the time wrap
    push_word(ACT_PLAY, EV_ERROR,  1'b1, 32'hFFFF_FF00);
    push_word(ACT_TICK, EV_OFF,    1'b0, 32'h0000_0100);
    // restart while running, then off under the lock
    push_word(ACT_PLAY, EV_START,  1'b0, 32'h0000_0200);
    push_word(ACT_PLAY, EV_OFF,    1'b1, 32'h0000_0300);
    push_word(ACT_TICK, EV_OFF,    1'b0, 32'h0000_0400);
    push_word(ACT_PLAY, EV_READY,  1'b0, 32'd1000);
    push_word(ACT_PLAY, EV_STOP,   1'b0, 32'd1100);
    push_word(ACT_TICK, EV_OFF,    1'b0, 32'd2100);
    push_word(ACT_PLAY, EV_DONE,   1'b0, 32'd3000);
    push_word(ACT_TICK, EV_OFF,    1'b0, 32'd4000);
    push_word(ACT_PLAY, EV_UNUSED, 1'b1, 32'd4100);
    push_word(ACT_TICK, EV_OFF,    1'b0, 32'd4500);
    push_word(ACT_PLAY, EV_OFF,    1'b0, 32'd5000);
    push_word(ACT_TICK, EV_OFF,    1'b0, 32'd5000);

    // random part: mostly play-then-ticks sequences, some raw noise
    clock_ms = 32'd6000;
    while (words_to_send.size() < WORD_GOAL) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        clock_ms = $urandom;
      else if (pick == 1)
        clock_ms = 32'hFFFF_FC00 + $urandom_range(0, 255);
      if (pick < 8) begin
        push_word(ACT_PLAY, 3'($urandom_range(1, 6)), ($urandom_range(0, 4) == 0), clock_ms);
        n_ticks = $urandom_range(4, 30);
        for (int k = 0; k < n_ticks; k++) begin
          case ($urandom_range(0, 3))
            0: step_ms = $urandom_range(0, 40);
            1: step_ms = $urandom_range(100, 700);
            default: begin
              case ($urandom_range(0, 3))
                0: step_ms = 150;
                1: step_ms = 300;
                2: step_ms = 500;
                default: step_ms = 1000;
              endcase
              step_ms = step_ms - $urandom_range(0, 1);
            end
          endcase
          clock_ms = clock_ms + step_ms;
          if ($urandom_range(0, 24) == 0)
            push_word(ACT_PLAY, 3'($urandom), 1'($urandom), clock_ms);
          else
            push_word(ACT_TICK, 3'($urandom), 1'($urandom), clock_ms);
        end
      end else begin
        n_ticks = $urandom_range(1, 5);
        for (int k = 0; k < n_ticks; k++)
          push_word(1'($urandom), 3'($urandom), 1'($urandom), $urandom);
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (words_to_send.size() != 0 || in_valid || levels_due.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);

    if (n_err == 0)
      $display("buzzer_beep_pattern_sequencer_unit_tb: done, clean");
    else
      $display("buzzer_beep_pattern_sequencer_unit_tb: done, errors");
    $finish;
  end

endmodule
